// ===== sv/qdd_pkg.sv =====
// Shared types, constants and a helper function of the quadrature detent decoder.
package qdd_pkg;

    localparam int unsigned PhaseW = 2;
    localparam int unsigned CountW = 6;
    localparam int unsigned CfgW   = 5;

    typedef logic [PhaseW-1:0]        phase_t;
    typedef logic signed [1:0]        dir_t;
    typedef logic signed [CountW-1:0] count_t;
    typedef logic [CfgW-1:0]          cfg_t;

    // One registered sample travelling from the input stage to the core.
    typedef struct packed {
        logic   valid;
        phase_t phase;
    } qdd_item_t;

    localparam cfg_t DETENT_LIMIT  = 5'd16;
    localparam cfg_t DEFAULT_EDGES = 5'd4;

    localparam phase_t PHASE_REST_LOW  = 2'b00;
    localparam phase_t PHASE_REST_HIGH = 2'b11;

    localparam dir_t DIR_NONE = 2'sb00;
    localparam dir_t DIR_CW   = 2'sb01;
    localparam dir_t DIR_CCW  = 2'sb11;

    // Transition table indexed by {previous phase, new phase}.
    localparam dir_t STEP_TABLE [16] = '{
        DIR_NONE, DIR_CW,   DIR_CCW,  DIR_NONE,
        DIR_CCW,  DIR_NONE, DIR_NONE, DIR_CW,
        DIR_CW,   DIR_NONE, DIR_NONE, DIR_CCW,
        DIR_NONE, DIR_CCW,  DIR_CW,   DIR_NONE
    };

    // Zero selects the default, values above the limit saturate.
    function automatic cfg_t effective_edges(input cfg_t raw);
        cfg_t res;
        if (raw == '0) begin
            res = DEFAULT_EDGES;
        end else if (raw > DETENT_LIMIT) begin
            res = DETENT_LIMIT;
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage

// ===== sv/qdd_in_stage.sv =====
// Input register stage: captures one A/B sample request from the slave side.
module qdd_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              core_ready,
    output qdd_pkg::qdd_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    qdd_pkg::phase_t   phase_reg;
    logic              load;

    assign s_tready = !valid_reg || core_ready;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (core_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Phase is (A << 1) | B; A sits in bit 0 of tdata and B in bit 1.
    always_ff @(posedge aclk) begin
        if (load) begin
            phase_reg <= {s_tdata[0], s_tdata[1]};
        end
    end

    assign item.valid = valid_reg;
    assign item.phase = phase_reg;

endmodule

// ===== sv/qdd_core.sv =====
// Decoder core: transition lookup, edge accumulator, detent decision and result register.
module qdd_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  qdd_pkg::qdd_item_t item,
    output logic               core_ready,
    input  qdd_pkg::cfg_t      edges,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata
);

    logic              primed_reg;
    logic              primed_next;
    qdd_pkg::phase_t   last_phase_reg;
    qdd_pkg::phase_t   last_phase_next;
    qdd_pkg::count_t   edge_count_reg;
    qdd_pkg::count_t   edge_count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    qdd_pkg::dir_t     dir_reg;
    qdd_pkg::dir_t     dir_next;

    logic              advance;
    qdd_pkg::dir_t     step;
    qdd_pkg::count_t   sum;
    qdd_pkg::count_t   lim;
    logic              hit_pos;
    logic              hit_neg;
    logic              at_rest;

    assign core_ready = !out_valid_reg || m_tready;
    assign advance    = item.valid && core_ready;

    assign step    = qdd_pkg::STEP_TABLE[{last_phase_reg, item.phase}];
    assign sum     = edge_count_reg + {{(qdd_pkg::CountW-2){step[1]}}, step};
    assign lim     = {1'b0, edges};
    assign hit_pos = (sum >= lim);
    assign hit_neg = (sum <= -lim);
    assign at_rest = (item.phase == qdd_pkg::PHASE_REST_LOW)
                  || (item.phase == qdd_pkg::PHASE_REST_HIGH);

    always_comb begin
        primed_next     = primed_reg;
        last_phase_next = last_phase_reg;
        edge_count_next = edge_count_reg;
        dir_next        = qdd_pkg::DIR_NONE;
        if (!primed_reg) begin
            primed_next     = 1'b1;
            last_phase_next = item.phase;
            edge_count_next = '0;
        end else if (step != qdd_pkg::DIR_NONE) begin
            last_phase_next = item.phase;
            edge_count_next = sum;
            if (hit_pos || hit_neg) begin
                if (at_rest) begin
                    edge_count_next = '0;
                    dir_next        = hit_pos ? qdd_pkg::DIR_CW : qdd_pkg::DIR_CCW;
                end else begin
                    edge_count_next = hit_pos ? lim : -lim;
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg     <= 1'b0;
            last_phase_reg <= '0;
            edge_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                primed_reg     <= primed_next;
                last_phase_reg <= last_phase_next;
                edge_count_reg <= edge_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dir_reg <= dir_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, dir_reg};

    // The accumulator never leaves the range of the largest detent limit.
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (edge_count_reg <= $signed({1'b0, qdd_pkg::DETENT_LIMIT}))
        && (edge_count_reg >= -$signed({1'b0, qdd_pkg::DETENT_LIMIT})))
        else $error("edge accumulator out of range");

    // A reported detent always leaves the accumulator cleared.
    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && dir_next != qdd_pkg::DIR_NONE) |=> (edge_count_reg == '0))
        else $error("accumulator not cleared after a detent");

    // The priming sample never reports and always primes.
    a_prime_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !primed_reg) |=> (primed_reg && dir_reg == qdd_pkg::DIR_NONE))
        else $error("priming sample reported a direction");

endmodule

// ===== sv/quadrature_detent_decoder.sv =====
// Top level of the quadrature detent decoder: configuration register and stage wiring.
//
// Each slave request carries one sampled A/B pair from a rotary encoder and
// produces exactly one master request with a direction: +1 clockwise, -1
// counter-clockwise, 0 when no detent was completed. The first sample after
// reset only records the starting phase. Valid single-bit transitions move an
// edge accumulator; repeats and double changes are ignored. When the
// accumulator reaches the edges-per-detent count, a click is reported if the
// encoder sits at a rest phase (both channels low or both high), otherwise the
// accumulator holds at the limit until it does. The block accepts one sample
// every clock while results are taken on the master side. An accepted sample
// is held in the input register, and its result in the result register until
// the master side takes it. The rate is set by the combinational table
// lookup and accumulator update in the core between the input and result
// registers. A result that waits on the master side holds the core; the input
// register can still capture one more sample, and after that s_tready stays
// low until the waiting result is taken. s_tready follows m_tready in the same
// cycle. The edges-per-detent register is written through the cfg port, is
// always ready, and should only be changed while no samples are in flight;
// zero selects four per detent and values above sixteen are treated as sixteen.
module quadrature_detent_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] phase_a, [1] phase_b, [7:2] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] direction (signed), [7:2] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data   // [4:0] detent_edges
);

    qdd_pkg::cfg_t      edges_reg;
    qdd_pkg::cfg_t      edges_next;
    qdd_pkg::qdd_item_t item;
    logic               core_ready;

    // The register always takes a write in the cycle it is offered.
    assign cfg_ready = 1'b1;

    always_comb begin
        edges_next = edges_reg;
        if (cfg_valid && cfg_ready) begin
            edges_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edges_reg <= qdd_pkg::DEFAULT_EDGES;
        end else begin
            edges_reg <= edges_next;
        end
    end

    qdd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .core_ready (core_ready),
        .item       (item)
    );

    qdd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (item),
        .core_ready (core_ready),
        .edges      (qdd_pkg::effective_edges(edges_reg)),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
